@@ rtl/lwt_pkg.sv @@
// Package for the list/word/number/string tokenizer.
// Holds the phase, event and error codes, field widths and the result struct.
// No dependencies; every other RTL file imports it.
`default_nettype none

package lwt_pkg;

    // Width of the number accumulator; numbers saturate at 2**NUM_BITS - 1.
    localparam int NUM_BITS = 32;
    // Widths of the result fields on the output channel.
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int KIND_W   = 3;
    localparam int ERR_W    = 3;

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;

    typedef enum logic [3:0] {
        PH_START     = 4'd0,
        PH_LOPEN     = 4'd1,
        PH_LCLOSE    = 4'd2,
        PH_WORD      = 4'd3,
        PH_WORD_OUT  = 4'd4,
        PH_NUM       = 4'd5,
        PH_NUM_OUT   = 4'd6,
        PH_STR       = 4'd7,
        PH_STR_CHECK = 4'd8,
        PH_STR_OUT   = 4'd9
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        EV_OPEN  = 3'd0,
        EV_CLOSE = 3'd1,
        EV_NUM   = 3'd2,
        EV_WBYTE = 3'd3,
        EV_WDONE = 3'd4,
        EV_SBYTE = 3'd5,
        EV_SDONE = 3'd6,
        EV_ERR   = 3'd7
    } event_kind_t;

    typedef enum logic [ERR_W-1:0] {
        ER_SPACE   = 3'd0,
        ER_OPEN    = 3'd1,
        ER_CLOSE   = 3'd2,
        ER_DIGIT   = 3'd3,
        ER_COLON   = 3'd4,
        ER_WORD    = 3'd5,
        ER_ILLEGAL = 3'd6
    } error_code_t;

    typedef struct packed {
        logic [KIND_W-1:0]  event_kind;
        logic [BYTE_W-1:0]  item_byte;
        logic [VALUE_W-1:0] number_value;
        logic [ERR_W-1:0]   error_code;
    } token_t;

endpackage

`default_nettype wire

@@ rtl/lwt_channels.sv @@
// Valid/ready channel interfaces for the tokenizer: raw bytes in, events out.
// Depends on lwt_pkg for the field widths.
`default_nettype none

interface lwt_byte_if;
    import lwt_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface lwt_event_if;
    import lwt_pkg::*;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  event_kind;
    logic [BYTE_W-1:0]  item_byte;
    logic [VALUE_W-1:0] number_value;
    logic [ERR_W-1:0]   error_code;

    modport source (output valid, output event_kind, output item_byte,
                    output number_value, output error_code, input ready);
    modport sink   (input valid, input event_kind, input item_byte,
                    input number_value, input error_code, output ready);
endinterface

`default_nettype wire

@@ rtl/list_word_number_string_tokenizer.sv @@
// Top level of the list/word/number/string tokenizer.
// Depends on lwt_pkg, lwt_channels, lwt_in_stage and lwt_lexer.
//
// Usage: raw protocol bytes arrive on the stream channel, one byte per
// transaction. Each byte yields at most one event on the tokens channel:
// list open, list close, number done, word byte, word done, string byte,
// string done (with the string length) or an error with a class code.
// Bytes that only advance the tokenizer, such as digits of a number or a
// space after a paren, produce no event.
// Path: a byte accepted at a clock edge is held in the input register and is
// stepped through the phase machine once the result register can take an
// event; that event is loaded into the result register as the step ends and
// is shown on tokens until the receiver takes it.
// Throughput: one byte per clock cycle while the result register is free;
// the phase, accumulator and string counters are all updated in that single
// step, with the saturating multiply-by-ten built from two shifts and an add.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// tokenizer to the start phase with all counters at zero.
// Stall: when the receiver holds tokens.ready low with an event waiting,
// the held byte stays put and stream.ready drops once the input register
// is full; no byte or event is lost or repeated.
`default_nettype none

module list_word_number_string_tokenizer (
    input  wire logic    clk,
    input  wire logic    rst_n,
    lwt_byte_if.sink     stream,
    lwt_event_if.source  tokens
);
    import lwt_pkg::*;

    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              out_free;
    logic              step;
    logic              res_valid;
    token_t            res;

    logic              tok_valid_reg;
    logic              tok_valid_next;
    token_t            tok_reg;

    // The result register can take a new event when empty or being drained.
    assign out_free = !tok_valid_reg || tokens.ready;
    assign step     = held_valid && out_free;

    lwt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .advance    (step),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    lwt_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        tok_valid_next = tok_valid_reg;
        if (out_free)
        begin
            tok_valid_next = step && res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            tok_reg <= res;
        end
    end

    assign tokens.valid        = tok_valid_reg;
    assign tokens.event_kind   = tok_reg.event_kind;
    assign tokens.item_byte    = tok_reg.item_byte;
    assign tokens.number_value = tok_reg.number_value;
    assign tokens.error_code   = tok_reg.error_code;

endmodule

`default_nettype wire

@@ rtl/lwt_in_stage.sv @@
// Input register of the tokenizer: captures one byte per transaction.
// Depends on lwt_pkg and the lwt_byte_if interface.
`default_nettype none

module lwt_in_stage (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    lwt_byte_if.sink                    stream,
    input  wire logic                   advance,
    output logic                        held_valid,
    output logic [lwt_pkg::BYTE_W-1:0]  held_byte
);
    import lwt_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              take;

    // The held byte leaves when the lexer steps on it, so a new one may land.
    assign stream.ready = !valid_reg || advance;
    assign take         = stream.valid && stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= stream.data_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

`default_nettype wire

@@ rtl/lwt_lexer.sv @@
// Tokenizer phase machine with number accumulator and string counters.
// One byte per step; produces at most one event. Depends on lwt_pkg.
`default_nettype none

module lwt_lexer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [lwt_pkg::BYTE_W-1:0] data_byte,
    output logic                       res_valid,
    output lwt_pkg::token_t            res
);
    import lwt_pkg::*;

    localparam logic [NUM_BITS-1:0] NUM_MAX = {NUM_BITS{1'b1}};

    phase_t              phase_reg, phase_next;
    logic [NUM_BITS-1:0] acc_reg, acc_next;
    logic [NUM_BITS-1:0] remain_reg, remain_next;
    logic [NUM_BITS-1:0] length_reg, length_next;

    logic                is_space, is_open, is_close, is_digit, is_colon, is_word;
    logic                sep;
    logic [3:0]          digit;
    logic [NUM_BITS+3:0] scaled;
    logic [NUM_BITS-1:0] acc_step;
    logic [NUM_BITS-1:0] remain_dec;

    assign is_space = (data_byte == CH_SPACE) || (data_byte == CH_LF);
    assign is_open  = (data_byte == CH_OPEN);
    assign is_close = (data_byte == CH_CLOSE);
    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign is_colon = (data_byte == CH_COLON);
    assign is_word  = ((data_byte >= CH_LO_A) && (data_byte <= CH_LO_Z))
                   || ((data_byte >= CH_UP_A) && (data_byte <= CH_UP_Z))
                   || (data_byte == CH_DASH);
    assign digit    = data_byte[3:0];

    assign sep = (phase_reg == PH_START) || (phase_reg == PH_WORD_OUT)
              || (phase_reg == PH_NUM_OUT) || (phase_reg == PH_STR_OUT);

    // acc*10 + d, saturating: overflow exactly when the full sum passes the maximum.
    assign scaled   = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                    + {{NUM_BITS{1'b0}}, digit};
    assign acc_step = (scaled > {4'b0000, NUM_MAX}) ? NUM_MAX : scaled[NUM_BITS-1:0];

    assign remain_dec = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        remain_next = remain_reg;
        length_next = length_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (phase_reg == PH_STR)
        begin
            remain_next = remain_dec;
            if (remain_dec == '0)
            begin
                phase_next = PH_STR_CHECK;
            end
            res_valid      = 1'b1;
            res.event_kind = EV_SBYTE;
            res.item_byte  = data_byte;
        end
        else if (is_space)
        begin
            unique case (phase_reg)
                PH_WORD:
                begin
                    phase_next     = PH_WORD_OUT;
                    res_valid      = 1'b1;
                    res.event_kind = EV_WDONE;
                end
                PH_LOPEN, PH_LCLOSE:
                begin
                    phase_next = PH_START;
                end
                PH_NUM:
                begin
                    phase_next       = PH_NUM_OUT;
                    res_valid        = 1'b1;
                    res.event_kind   = EV_NUM;
                    res.number_value = VALUE_W'(acc_reg);
                end
                PH_STR_CHECK:
                begin
                    phase_next       = PH_STR_OUT;
                    res_valid        = 1'b1;
                    res.event_kind   = EV_SDONE;
                    res.number_value = VALUE_W'(length_reg);
                end
                PH_START, PH_WORD_OUT, PH_NUM_OUT, PH_STR_OUT:
                begin
                    phase_next = phase_reg;
                end
                default:
                begin
                    res_valid      = 1'b1;
                    res.event_kind = EV_ERR;
                    res.error_code = ER_SPACE;
                end
            endcase
        end
        else if (is_open || is_close)
        begin
            res_valid = 1'b1;
            if (sep)
            begin
                phase_next     = is_open ? PH_LOPEN : PH_LCLOSE;
                res.event_kind = is_open ? EV_OPEN : EV_CLOSE;
            end
            else
            begin
                res.event_kind = EV_ERR;
                res.error_code = is_open ? ER_OPEN : ER_CLOSE;
            end
        end
        else if (is_digit)
        begin
            if (sep)
            begin
                phase_next = PH_NUM;
                acc_next   = NUM_BITS'(digit);
            end
            else if (phase_reg == PH_NUM)
            begin
                acc_next = acc_step;
            end
            else if (phase_reg == PH_WORD)
            begin
                res_valid      = 1'b1;
                res.event_kind = EV_WBYTE;
                res.item_byte  = data_byte;
            end
            else
            begin
                res_valid      = 1'b1;
                res.event_kind = EV_ERR;
                res.error_code = ER_DIGIT;
            end
        end
        else if (is_colon)
        begin
            if (phase_reg == PH_NUM)
            begin
                length_next = acc_reg;
                remain_next = acc_reg;
                phase_next  = (acc_reg == '0) ? PH_STR_CHECK : PH_STR;
            end
            else
            begin
                res_valid      = 1'b1;
                res.event_kind = EV_ERR;
                res.error_code = ER_COLON;
            end
        end
        else if (is_word)
        begin
            res_valid = 1'b1;
            if (sep || (phase_reg == PH_WORD))
            begin
                phase_next     = PH_WORD;
                res.event_kind = EV_WBYTE;
                res.item_byte  = data_byte;
            end
            else
            begin
                res.event_kind = EV_ERR;
                res.error_code = ER_WORD;
            end
        end
        else
        begin
            res_valid      = 1'b1;
            res.event_kind = EV_ERR;
            res.error_code = ER_ILLEGAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            acc_reg    <= '0;
            remain_reg <= '0;
            length_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            remain_reg <= remain_next;
            length_reg <= length_next;
        end
    end

endmodule

`default_nettype wire
